// ===== rtl/ueest_pkg.sv =====
// Shared types and constants for the utilization moving-average estimator.
package ueest_pkg;

  localparam int TIME_BITS_DEF = 48;
  localparam int FRAC_BITS_DEF = 16;

  localparam int TICK_W  = 31;
  localparam int TPS_W   = 14;
  localparam int WGT_W   = 16;
  localparam int USAGE_W = 24;
  localparam int US_W    = 20;
  localparam int CHUNK_W = 16;
  localparam int CNT_W   = $clog2(USAGE_W + 1);
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [US_W-1:0]    US_PER_SEC  = US_W'(1000000);
  localparam logic [TPS_W-1:0]   TPS_RESET   = TPS_W'(100);
  localparam logic [WGT_W-1:0]   WGT_RESET   = WGT_W'(5243);
  localparam logic [WGT_W:0]     WEIGHT_ONE  = (WGT_W+1)'(1) << WGT_W;
  localparam logic [USAGE_W-1:0] USAGE_MAX   = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TPS    = 2'd0,
    REG_WEIGHT = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_EMPTY,
    PH_ONE,
    PH_VALID
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_CHECK,
    S_DIV,
    S_BLEND_MUL,
    S_BLEND_ADD,
    S_OUT
  } state_t;

  typedef struct packed {
    logic capture;
    logic mul_step;
    logic check;
    logic div_step;
    logic blend_mul;
    logic blend_add;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic sat;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/ueest_ctrl.sv =====
// Sequencer for the estimator: accept, denominator build, divide, blend, deliver.
module ueest_ctrl #(
  parameter int TIME_BITS = ueest_pkg::TIME_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  ueest_pkg::sts_t   sts,
  output ueest_pkg::cmd_t   cmd
);
  import ueest_pkg::*;

  localparam int N_CHUNKS = (TIME_BITS + CHUNK_W - 1) / CHUNK_W;

  state_t            state, state_next;
  logic [CNT_W-1:0]  cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = sts.skip ? S_OUT : S_MUL;
      end
      S_MUL: begin
        if (cnt == '0) state_next = S_CHECK;
      end
      S_CHECK: begin
        state_next = sts.sat ? S_BLEND_MUL : S_DIV;
      end
      S_DIV: begin
        if (cnt == '0) state_next = S_BLEND_MUL;
      end
      S_BLEND_MUL: state_next = S_BLEND_ADD;
      S_BLEND_ADD: state_next = S_OUT;
      S_OUT: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cnt_next = cnt;
    case (state)
      S_IDLE:  cnt_next = CNT_W'(N_CHUNKS - 1);
      S_MUL:   cnt_next = (cnt == '0) ? CNT_W'(USAGE_W - 1) : cnt - 1'b1;
      S_CHECK: cnt_next = CNT_W'(USAGE_W - 1);
      S_DIV:   cnt_next = cnt - 1'b1;
      default: cnt_next = cnt;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      S_MUL:       cmd.mul_step  = 1'b1;
      S_CHECK:     cmd.check     = 1'b1;
      S_DIV:       cmd.div_step  = 1'b1;
      S_BLEND_MUL: cmd.blend_mul = 1'b1;
      S_BLEND_ADD: cmd.blend_add = 1'b1;
      S_OUT:       cmd.out_load  = sts.out_free;
      default:     cmd           = '0;
    endcase
  end

endmodule

// ===== rtl/ueest_dpath.sv =====
// Datapath: sample state, tick-rate product, restoring divider, blend and output register.
module ueest_dpath #(
  parameter int TIME_BITS = ueest_pkg::TIME_BITS_DEF,
  parameter int FRAC_BITS = ueest_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  ueest_pkg::cmd_t                  cmd,
  output ueest_pkg::sts_t                  sts,
  input  logic                             cfg_we,
  input  logic [ueest_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ueest_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [ueest_pkg::TICK_W-1:0]     busy_ticks,
  input  logic [TIME_BITS-1:0]             time_us,
  input  logic                             read_failed,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             status,
  output logic                             usage_valid,
  output logic [ueest_pkg::USAGE_W-1:0]    usage
);
  import ueest_pkg::*;

  localparam int N_CHUNKS = (TIME_BITS + CHUNK_W - 1) / CHUNK_W;
  localparam int DT_W     = N_CHUNKS * CHUNK_W;
  localparam int DEN_W    = DT_W + TPS_W;
  localparam int NUMP_W   = TICK_W + US_W;
  localparam int NUM_W    = NUMP_W + FRAC_BITS;
  localparam int DSH_W    = DEN_W + USAGE_W;
  localparam int CMP_W    = (NUM_W > DSH_W) ? NUM_W : DSH_W;
  localparam int PROD_W   = WGT_W + 1 + USAGE_W;

  logic [TPS_W-1:0]   tps;
  logic [WGT_W-1:0]   weight;
  phase_t             phase;
  logic [TICK_W-1:0]  last_ticks;
  logic [TIME_BITS-1:0] last_time;
  logic [USAGE_W-1:0] smoothed;
  logic               failed;
  logic [TICK_W-1:0]  dticks;
  logic [DT_W-1:0]    dt_sh;
  logic [DEN_W-1:0]   den;
  logic [CMP_W-1:0]   rem;
  logic [CMP_W-1:0]   dsh;
  logic [USAGE_W-1:0] quo;
  logic [PROD_W-1:0]  p_old, p_new;

  logic [TICK_W-1:0]        dticks_in;
  logic [TIME_BITS-1:0]     dt_in;
  logic [CHUNK_W+TPS_W-1:0] chunk_prod;
  logic [NUMP_W-1:0]        nump;
  logic [CMP_W-1:0]         den_top;
  logic                     sat;
  logic                     ge;
  logic [PROD_W-1:0]        blend_sum;
  logic [USAGE_W-1:0]       blended;

  assign dticks_in  = (busy_ticks >= last_ticks) ? busy_ticks - last_ticks : '0;
  assign dt_in      = time_us - last_time;
  assign chunk_prod = dt_sh[DT_W-1 -: CHUNK_W] * tps;
  assign nump       = NUMP_W'(dticks) * NUMP_W'(US_PER_SEC);
  assign den_top    = CMP_W'(den) << USAGE_W;
  assign sat        = (den == '0) || (rem >= den_top);
  assign ge         = rem >= dsh;
  assign blend_sum  = p_old + p_new + PROD_W'(WEIGHT_ONE >> 1);
  assign blended    = blend_sum[WGT_W +: USAGE_W];

  assign sts.skip     = read_failed || (phase == PH_EMPTY);
  assign sts.sat      = sat;
  assign sts.out_free = !out_valid || !out_stall;

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      tps       <= TPS_RESET;
      weight    <= WGT_RESET;
      phase     <= PH_EMPTY;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TPS:    tps    <= cfg_data[TPS_W-1:0];
          REG_WEIGHT: weight <= cfg_data[WGT_W-1:0];
          default:    ;
        endcase
      end
      if (cmd.capture && !read_failed && phase == PH_EMPTY) phase <= PH_ONE;
      if (cmd.blend_add) phase <= PH_VALID;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      failed <= read_failed;
      den    <= '0;
      if (!read_failed) begin
        last_ticks <= busy_ticks;
        last_time  <= time_us;
        dticks     <= dticks_in;
        dt_sh      <= DT_W'(dt_in);
      end
    end
    // Build dt * tps one chunk at a time, top chunk first.
    if (cmd.mul_step) begin
      dt_sh <= dt_sh << CHUNK_W;
      den   <= (den << CHUNK_W) + DEN_W'(chunk_prod);
      rem   <= CMP_W'({nump, {FRAC_BITS{1'b0}}});
    end
    if (cmd.check) begin
      dsh <= den_top >> 1;
      quo <= sat ? USAGE_MAX : '0;
    end
    if (cmd.div_step) begin
      if (ge) rem <= rem - dsh;
      quo <= {quo[USAGE_W-2:0], ge};
      dsh <= dsh >> 1;
    end
    if (cmd.blend_mul) begin
      p_old <= PROD_W'((WEIGHT_ONE - (WGT_W+1)'(weight)) * smoothed);
      p_new <= PROD_W'(weight * quo);
    end
    // Second sample loads the raw ratio; later ones take the blend.
    if (cmd.blend_add) smoothed <= (phase == PH_ONE) ? quo : blended;
    if (cmd.out_load) begin
      status      <= failed;
      usage_valid <= (phase == PH_VALID);
      usage       <= (phase == PH_VALID) ? smoothed : '0;
    end
  end

endmodule

// ===== rtl/utilization_ema_estimator_unit.sv =====
// Utilization estimator top level: exponential moving average of the busy-tick ratio.
//
// Each accepted sample yields exactly one result. A failed read or the first good
// sample goes straight to the output register. Every later sample passes through
// one multiply step per 16-bit chunk of the elapsed time in the 16x14 tick-rate
// multiplier, a saturation check, 24 steps of the restoring divider for the Q8.16
// ratio, a multiply and an add step of blending through the weight multipliers, and
// the output load. A zero denominator or a ratio that saturates skips the divider.
// A result that finds the output register still stalled waits in the load step
// until the register frees. One sample is in flight at a time; a new one is taken
// while the previous result still waits in the output register. Configuration
// writes are always ready.
module utilization_ema_estimator_unit #(
  parameter int TIME_BITS = ueest_pkg::TIME_BITS_DEF,
  parameter int FRAC_BITS = ueest_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [ueest_pkg::TICK_W-1:0]     busy_ticks,
  input  logic [TIME_BITS-1:0]             time_us,
  input  logic                             read_failed,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             status,
  output logic                             usage_valid,
  output logic [ueest_pkg::USAGE_W-1:0]    usage,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ueest_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ueest_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ueest_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  ueest_ctrl #(
    .TIME_BITS (TIME_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ueest_dpath #(
    .TIME_BITS (TIME_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .busy_ticks  (busy_ticks),
    .time_us     (time_us),
    .read_failed (read_failed),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .usage_valid (usage_valid),
    .usage       (usage)
  );

  // One sample in flight: a transfer in blocks the input on the next cycle.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a sample is in flight");

  // Usage reads zero until two good samples have been seen.
  a_usage_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !usage_valid) |-> (usage == '0))
    else $error("usage nonzero without usage_valid");

  // A result is loaded only once the previous one has left or is leaving.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("output register overwritten before transfer");

endmodule
